// ===== sv/uddw_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder with display width: shared package
// Types, codes and decode helpers used by the controller and the datapath.
// ----------------------------------------------------------------------------
package uddw_pkg;

   typedef logic [2:0] kind_type;

   localparam kind_type KIND_REPL  = 3'd0;
   localparam kind_type KIND_HELD0 = 3'd1;
   localparam kind_type KIND_HELD1 = 3'd2;
   localparam kind_type KIND_BYTE  = 3'd3;
   localparam kind_type KIND_SEQ   = 3'd4;

   localparam logic [20:0] REPLACEMENT_CP = 21'd63;
   localparam logic [7:0]  TAB_BYTE       = 8'h09;
   localparam logic [7:0]  NEWLINE_BYTE   = 8'h0A;

   typedef struct packed {
      logic accept_ready;
      logic emit;
      logic use_rem;
      logic div_start;
      logic div_step;
   } ctl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic new_has_results;
      logic slot_is_tab;
      logic slot_last;
      logic out_free;
      logic div_done;
   } dp_status_type;

   function automatic logic [2:0] seq_length(input logic [7:0] b);
      logic [2:0] len;
      if (b[7] == 1'b0) begin
         len = 3'd1;
      end else if (b[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         len = 3'd4;
      end else begin
         len = 3'd1;
      end
      return len;
   endfunction

   function automatic logic [1:0] glyph_width(input logic [20:0] cp);
      logic [1:0] w;
      if (cp < 21'd32) begin
         w = 2'd0;
      end else if ((cp >= 21'h01100 && cp <= 21'h0115F) ||
                   (cp >= 21'h02E80 && cp <= 21'h09FFF) ||
                   (cp >= 21'h0AC00 && cp <= 21'h0D7AF) ||
                   (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
                   (cp >= 21'h0FE10 && cp <= 21'h0FE1F) ||
                   (cp >= 21'h0FE30 && cp <= 21'h0FE6F) ||
                   (cp >= 21'h0FF00 && cp <= 21'h0FF60) ||
                   (cp >= 21'h0FFE0 && cp <= 21'h0FFE6) ||
                   (cp >= 21'h20000 && cp <= 21'h2FFFF)) begin
         w = 2'd2;
      end else begin
         w = 2'd1;
      end
      return w;
   endfunction

endpackage

// ===== sv/uddw_ctrl.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder with display width: controller
// Sequences the result slots of each byte and the tab remainder unit.
// ----------------------------------------------------------------------------
module uddw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  uddw_pkg::dp_status_type status,
   output uddw_pkg::ctl_cmd_type   cmd
);
   import uddw_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_TAB  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept_ready = 1'b1;
         end
         ST_RUN: begin
            if (status.slot_is_tab) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.slot_last) begin
                  cmd.accept_ready = 1'b1;
                  state_in         = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_TAB;
            end
         end
         ST_TAB: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.use_rem = 1'b1;
               if (status.slot_last) begin
                  cmd.accept_ready = 1'b1;
                  state_in         = ST_IDLE;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.accept_ready && status.req_valid) begin
         state_in = status.new_has_results ? ST_RUN : ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/uddw_datapath.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder with display width: datapath
// Sequence state, result plan, column tracking, tab remainder and output word.
// ----------------------------------------------------------------------------
module uddw_datapath #(
   parameter int COLUMN_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [47:0]             rsp_tdata,
   output logic                    rsp_tuser,
   output logic                    rsp_tlast,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [4:0]              csr_data,
   input  uddw_pkg::ctl_cmd_type   cmd,
   output uddw_pkg::dp_status_type status
);
   import uddw_pkg::*;

   localparam int CNT_W = $clog2(COLUMN_BITS + 1);

   logic                   accept;
   logic [4:0]             tab_ff;
   logic [4:0]             ts;
   logic [7:0]             lead_ff, lead_in;
   logic [2:0]             exp_ff, exp_in;
   logic [1:0]             cnt_ff, cnt_in;
   logic [7:0]             held_ff [2];
   logic                   hold_wr;
   logic                   hold_idx;
   logic [7:0]             byte_ff;
   logic [2:0]             seq_len_ff, seq_len_in;
   kind_type               plan_kind [4];
   logic [2:0]             plan_n;
   kind_type               plan_ff [4];
   logic [2:0]             plan_n_ff;
   logic [1:0]             slot_ff;
   logic [COLUMN_BITS-1:0] column_ff, column_in;
   logic [COLUMN_BITS-1:0] shift_ff;
   logic [4:0]             rem_ff, rem_in;
   logic [5:0]             rem_sh;
   logic [CNT_W-1:0]       div_cnt_ff;
   logic                   rsp_valid_ff;
   logic [47:0]            rsp_data_ff;
   logic                   rsp_user_ff, rsp_last_ff;
   logic [7:0]             b;
   logic [2:0]             blen;
   logic                   pend, cont;
   kind_type               kind;
   logic [20:0]            cp, seq_cp;
   logic [2:0]             count;
   logic                   repl, is_tab, is_nl;
   logic [4:0]             width;
   logic [COLUMN_BITS:0]   col_sum;
   logic [31:0]            col_wide;
   logic                   slot_last;

   assign csr_ready  = 1'b1;
   assign req_tready = cmd.accept_ready;
   assign accept     = req_tvalid && cmd.accept_ready;

   assign ts = (tab_ff == 5'd0) ? 5'd1 : ((tab_ff > 5'd16) ? 5'd16 : tab_ff);

   always_comb begin
      b          = req_tdata;
      blen       = seq_length(b);
      cont       = (b[7:6] == 2'b10);
      pend       = (exp_ff >= 3'd2) && (exp_ff <= 3'd4);
      lead_in    = lead_ff;
      exp_in     = exp_ff;
      cnt_in     = cnt_ff;
      seq_len_in = seq_len_ff;
      hold_wr    = 1'b0;
      hold_idx   = cnt_ff[0];
      plan_kind  = '{default: KIND_REPL};
      plan_n     = 3'd0;
      if (!pend) begin
         exp_in = 3'd0;
         if (blen == 3'd1) begin
            plan_kind[0] = KIND_BYTE;
            plan_n       = 3'd1;
         end else begin
            lead_in = b;
            exp_in  = blen;
            cnt_in  = 2'd0;
            if (req_tlast) begin
               plan_n = 3'd1;
               exp_in = 3'd0;
            end
         end
      end else if (cont) begin
         if (({1'b0, cnt_ff} + 3'd2) >= exp_ff) begin
            plan_kind[0] = KIND_SEQ;
            plan_n       = 3'd1;
            exp_in       = 3'd0;
            cnt_in       = 2'd0;
            seq_len_in   = exp_ff;
         end else begin
            hold_wr = 1'b1;
            cnt_in  = cnt_ff + 2'd1;
            if (req_tlast) begin
               plan_kind[1] = KIND_HELD0;
               plan_kind[2] = KIND_HELD1;
               plan_n       = (cnt_in == 2'd2) ? 3'd3 : 3'd2;
               exp_in       = 3'd0;
               cnt_in       = 2'd0;
            end
         end
      end else begin
         plan_kind[1] = KIND_HELD0;
         plan_kind[2] = KIND_HELD1;
         plan_n       = 3'd1 + {1'b0, cnt_ff};
         cnt_in       = 2'd0;
         exp_in       = 3'd0;
         if (blen == 3'd1) begin
            plan_kind[plan_n[1:0]] = KIND_BYTE;
            plan_n                 = plan_n + 3'd1;
         end else begin
            lead_in = b;
            exp_in  = blen;
            if (req_tlast) begin
               plan_kind[plan_n[1:0]] = KIND_REPL;
               plan_n                 = plan_n + 3'd1;
               exp_in                 = 3'd0;
            end
         end
      end
   end

   always_comb begin
      kind = plan_ff[slot_ff];
      case (seq_len_ff)
         3'd2:    seq_cp = {10'd0, lead_ff[4:0], byte_ff[5:0]};
         3'd3:    seq_cp = {5'd0, lead_ff[3:0], held_ff[0][5:0], byte_ff[5:0]};
         default: seq_cp = {lead_ff[2:0], held_ff[0][5:0], held_ff[1][5:0], byte_ff[5:0]};
      endcase
      count = 3'd1;
      repl  = 1'b0;
      case (kind)
         KIND_REPL: begin
            cp   = REPLACEMENT_CP;
            repl = 1'b1;
         end
         KIND_HELD0: cp = {13'd0, held_ff[0]};
         KIND_HELD1: cp = {13'd0, held_ff[1]};
         KIND_BYTE:  cp = {13'd0, byte_ff};
         KIND_SEQ: begin
            cp    = seq_cp;
            count = seq_len_ff;
         end
         default: begin
            cp   = REPLACEMENT_CP;
            repl = 1'b1;
         end
      endcase
      is_tab    = (kind == KIND_BYTE) && (byte_ff == TAB_BYTE);
      is_nl     = (kind == KIND_BYTE) && (byte_ff == NEWLINE_BYTE);
      width     = cmd.use_rem ? (ts - rem_ff) : {3'd0, glyph_width(cp)};
      col_sum   = {1'b0, column_ff} + (COLUMN_BITS + 1)'(width);
      if (is_nl) begin
         column_in = '0;
      end else if (col_sum[COLUMN_BITS]) begin
         column_in = '1;
      end else begin
         column_in = col_sum[COLUMN_BITS-1:0];
      end
      col_wide  = 32'(column_ff);
      slot_last = (({1'b0, slot_ff} + 3'd1) == plan_n_ff);
      rem_sh    = {rem_ff, shift_ff[COLUMN_BITS-1]};
      rem_in    = (rem_sh >= {1'b0, ts}) ? 5'(rem_sh - {1'b0, ts}) : rem_sh[4:0];
   end

   always_comb begin
      status.req_valid       = req_tvalid;
      status.new_has_results = (plan_n != 3'd0);
      status.slot_is_tab     = is_tab;
      status.slot_last       = slot_last;
      status.out_free        = !rsp_valid_ff || rsp_tready;
      status.div_done        = (div_cnt_ff == CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_ff       <= 5'd4;
         lead_ff      <= '0;
         exp_ff       <= '0;
         cnt_ff       <= '0;
         column_ff    <= '0;
         plan_n_ff    <= '0;
         slot_ff      <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            tab_ff <= csr_data;
         end
         if (accept) begin
            lead_ff   <= lead_in;
            exp_ff    <= exp_in;
            cnt_ff    <= cnt_in;
            plan_n_ff <= plan_n;
            slot_ff   <= 2'd0;
         end else if (cmd.emit) begin
            slot_ff <= slot_ff + 2'd1;
         end
         if (cmd.emit) begin
            column_ff <= column_in;
         end
         if (cmd.div_start) begin
            div_cnt_ff <= CNT_W'(COLUMN_BITS);
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff - CNT_W'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff    <= req_tdata;
         seq_len_ff <= seq_len_in;
         plan_ff    <= plan_kind;
         if (hold_wr) begin
            held_ff[hold_idx] <= req_tdata;
         end
      end
      if (cmd.div_start) begin
         shift_ff <= column_ff;
         rem_ff   <= 5'd0;
      end else if (cmd.div_step) begin
         shift_ff <= {shift_ff[COLUMN_BITS-2:0], 1'b0};
         rem_ff   <= rem_in;
      end
      if (cmd.emit) begin
         rsp_data_ff <= {3'd0, col_wide[15:0], width, count, cp};
         rsp_user_ff <= repl;
         rsp_last_ff <= slot_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== sv/utf8_decode_display_width_top.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder with display width: top level
// A byte that yields no result is taken and the block stays ready for the next.
// One that yields results is taken, then emits one result a cycle unless stalled.
// The next byte is taken in the cycle its predecessor's last result is loaded.
// A tab first runs the bit-serial column remainder, holding back its result.
// Synchronous reset clears the sequence state, the column and tab_stop (4).
// ----------------------------------------------------------------------------
module utf8_decode_display_width_top #(
   parameter int COLUMN_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // code_point, byte_count, display_width, start_column
   output logic        rsp_tuser,   // replaced
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data     // tab_stop
);
   import uddw_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   uddw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   uddw_datapath #(
      .COLUMN_BITS (COLUMN_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ===== sv/uddw_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder with display width: port checker
// Watches the result port of the top level for malformed or unstable words.
// ----------------------------------------------------------------------------
module uddw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_reset_clears_valid: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   a_replaced_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[20:0] == 21'd63 && rsp_tdata[23:21] == 3'd1
         && rsp_tdata[28:24] == 5'd1)
      else $error("replacement word malformed");

   a_field_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:21] != 3'd0 && rsp_tdata[23:21] <= 3'd4
         && rsp_tdata[28:24] <= 5'd16)
      else $error("byte count or width out of range");

endmodule

bind utf8_decode_display_width_top uddw_checker u_chk (.*);
